// ===== hdl/fkr_pkg.sv =====
// Types and codes shared by the keyed-remove FIFO modules.
// No dependencies.
`default_nettype none

package fkr_pkg;

  // Command codes carried in the mode field
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_REMOVE  = 2'd1;
  localparam logic [1:0] MODE_DEQUEUE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] payload_in;
    logic [15:0] tag_in;
  } fkr_req_t;

  typedef struct packed {
    logic [31:0] payload_out;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } fkr_rsp_t;

  // One stored queue entry
  typedef struct packed {
    logic [31:0] payload;
    logic [15:0] tag;
  } fkr_entry_t;

endpackage

`default_nettype wire

// ===== hdl/fkr_entry_ram.sv =====
// Entry store of the keyed-remove FIFO: one write port, one registered read port.
// Depends on fkr_pkg for the entry type.
`default_nettype none

module fkr_entry_ram
  import fkr_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire fkr_entry_t        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output fkr_entry_t             rdata
);

  fkr_entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fifo_with_keyed_remove_core.sv =====
// Top level of the keyed-remove FIFO: command sequencer around the entry store.
// Depends on fkr_pkg and fkr_entry_ram.
`default_nettype none

// Queue of up to QUEUE_DEPTH tagged entries held in a circular buffer in one
// single-port-read memory. Each request yields one response; one request is
// worked on at a time. Insert, the unused mode and a command refused at once
// (insert when full, dequeue or remove when empty) are answered from the idle
// state; dequeue first passes through S_DEQ (memory read latency). Remove by
// tag reads one tag at a time from the head (S_SRD, S_SCMP) until the first
// match, then closes the gap by copying each later entry down one slot
// (S_MRD, S_MWR per entry moved); its run time depends only on the entry
// count, whether or not a match is found. The single read port of the entry
// memory sets these steps. The stores need no clearing after reset; the queue
// is usable as soon as reset is released. A new request is taken while the
// previous response still waits only if that response is accepted in the same
// cycle.
module fifo_with_keyed_remove_core
  import fkr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire fkr_req_t req_data,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output fkr_rsp_t      rsp_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEQ  = 6'b000010,
    S_SRD  = 6'b000100,
    S_SCMP = 6'b001000,
    S_MRD  = 6'b010000,
    S_MWR  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [15:0]      key, key_next;
  fkr_rsp_t         rsp_next;
  logic             rsp_load;

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  fkr_entry_t       ram_wdata, ram_rdata;

  logic             req_fire;
  logic [CNT_W-1:0] idx_p1, idx_p2, count_m1, count_p1;

  // Physical slot of a logical offset from the head
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_P) begin
      sum = sum - DEPTH_P;
    end
    return sum[PTR_W-1:0];
  endfunction

  // Low five bits of an entry count
  function automatic logic [4:0] occ(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] wide;
    wide = {5'b0, c};
    return wide[4:0];
  endfunction

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;
  assign idx_p1    = idx + CNT_W'(1);
  assign idx_p2    = idx + CNT_W'(2);
  assign count_m1  = count - CNT_W'(1);
  assign count_p1  = count + CNT_W'(1);

  fkr_entry_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequence each request through the entry memory
  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    key_next   = key;
    rsp_load   = 1'b0;
    rsp_next   = '{payload_out: 32'd0, status: STATUS_OK, occupancy: occ(count)};
    ram_we     = 1'b0;
    ram_waddr  = phys(head, count[PTR_W-1:0]);
    ram_wdata  = '{payload: req_data.payload_in, tag: req_data.tag_in};
    ram_re     = 1'b0;
    ram_raddr  = head;

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (req_data.mode)
            MODE_INSERT: begin
              rsp_load = 1'b1;
              if (count == DEPTH_C) begin
                rsp_next.status = STATUS_FULL;
              end else begin
                ram_we             = 1'b1;
                count_next         = count_p1;
                rsp_next.occupancy = occ(count_p1);
              end
            end
            MODE_DEQUEUE: begin
              if (count == '0) begin
                rsp_load        = 1'b1;
                rsp_next.status = STATUS_EMPTY;
              end else begin
                ram_re     = 1'b1;
                state_next = S_DEQ;
              end
            end
            MODE_REMOVE: begin
              if (count == '0) begin
                rsp_load        = 1'b1;
                rsp_next.status = STATUS_NOT_FOUND;
              end else begin
                key_next   = req_data.tag_in;
                idx_next   = '0;
                state_next = S_SRD;
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        // Hand out the head and advance it
        head_next            = phys(head, PTR_W'(1));
        count_next           = count_m1;
        rsp_load             = 1'b1;
        rsp_next.payload_out = ram_rdata.payload;
        rsp_next.occupancy   = occ(count_m1);
        state_next           = S_IDLE;
      end
      S_SRD: begin
        ram_re     = 1'b1;
        ram_raddr  = phys(head, idx[PTR_W-1:0]);
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (ram_rdata.tag == key) begin
          if (idx_p1 == count) begin
            // Match at the tail: nothing to move
            count_next         = count_m1;
            rsp_load           = 1'b1;
            rsp_next.occupancy = occ(count_m1);
            state_next         = S_IDLE;
          end else begin
            state_next = S_MRD;
          end
        end else if (idx_p1 == count) begin
          rsp_load        = 1'b1;
          rsp_next.status = STATUS_NOT_FOUND;
          state_next      = S_IDLE;
        end else begin
          idx_next   = idx_p1;
          state_next = S_SRD;
        end
      end
      S_MRD: begin
        ram_re     = 1'b1;
        ram_raddr  = phys(head, idx_p1[PTR_W-1:0]);
        state_next = S_MWR;
      end
      S_MWR: begin
        // Copy the later entry down into the gap
        ram_we    = 1'b1;
        ram_waddr = phys(head, idx[PTR_W-1:0]);
        ram_wdata = ram_rdata;
        if (idx_p2 == count) begin
          count_next         = count_m1;
          rsp_load           = 1'b1;
          rsp_next.occupancy = occ(count_m1);
          state_next         = S_IDLE;
        end else begin
          idx_next   = idx_p1;
          state_next = S_MRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers and response payload
  always_ff @(posedge clk) begin
    idx <= idx_next;
    key <= key_next;
    if (rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the keyed-remove FIFO core: a directed table, then random traffic.
// Every response is checked against a table value or an in-bench queue model of the entries.
// Depends on fkr_pkg and fifo_with_keyed_remove_core.
`timescale 1ns / 1ps

module tb_top
  import fkr_pkg::*;
();

  localparam int QUEUE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 500;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
  localparam int HOLD_CYCLES   = 250;
  localparam int IDLE_PERCENT  = 14;
  localparam int MAX_REPORTS   = 10;

  // Mode code with no meaning; the block must ignore it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    fkr_req_t cmd;
    int       reps;
    bit       typed;
    fkr_rsp_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  fkr_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  fkr_rsp_t rsp_data;

  fkr_entry_t held[$];
  fkr_rsp_t   pending_rsp[$];
  stim_row_t  stim_table[$];
  int         accepted_reqs = 0;
  int         rsp_count = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  bit         quiet = 1'b0;
  bit         held_off = 1'b0;

  fifo_with_keyed_remove_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the modelled queue and return the response it yields
  function automatic fkr_rsp_t apply_command(fkr_req_t cmd);
    fkr_rsp_t   r;
    fkr_entry_t e;
    int         hit;
    r = '0;
    hit = -1;
    case (cmd.mode)
      MODE_INSERT: begin
        if (held.size() >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          e.payload = cmd.payload_in;
          e.tag = cmd.tag_in;
          held.push_back(e);
        end
      end
      MODE_REMOVE: begin
        // oldest matching tag goes; the rest keep their order
        for (int i = 0; i < held.size(); i++) begin
          if (hit < 0 && held[i].tag == cmd.tag_in) hit = i;
        end
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          held.delete(hit);
        end
      end
      MODE_DEQUEUE: begin
        if (held.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          e = held.pop_front();
          r.payload_out = e.payload;
        end
      end
      default: ;
    endcase
    r.occupancy = 5'(held.size());
    return r;
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic [31:0] payload,
                         input logic [15:0] tag, input int reps, input bit typed,
                         input logic [1:0] status, input logic [31:0] payload_out,
                         input logic [4:0] occupancy);
    stim_row_t row;
    row.cmd.mode = mode;
    row.cmd.payload_in = payload;
    row.cmd.tag_in = tag;
    row.reps = reps;
    row.typed = typed;
    row.want.payload_out = payload_out;
    row.want.status = status;
    row.want.occupancy = occupancy;
    stim_table.push_back(row);
  endtask

  // Offer one request, hold it until taken, then record what it should yield
  task automatic issue(input fkr_req_t cmd, input bit typed, input fkr_rsp_t want);
    fkr_rsp_t predicted;
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= cmd;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = apply_command(cmd);
    pending_rsp.push_back(typed ? want : predicted);
    accepted_reqs++;
  endtask

  // Stop offering and wait for every outstanding response
  task automatic drain_pending();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table, then random traffic
  initial begin
    fkr_req_t cmd;
    stim_row_t row;
    int counted;
    int roll;
    int ins_bound;
    int rem_bound;
    bit mid_drained;

    add_row(MODE_DEQUEUE, 32'h0, 16'h0, 1, 1, STATUS_EMPTY, 32'h0, 5'd0);
    add_row(MODE_REMOVE, 32'h0, 16'h0, 1, 1, STATUS_NOT_FOUND, 32'h0, 5'd0);
    add_row(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, STATUS_OK, 32'h0, 5'd0);
    add_row(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, STATUS_OK, 32'h0, 5'd1);
    add_row(MODE_INSERT, 32'h0, 16'h0, 1, 1, STATUS_OK, 32'h0, 5'd2);
    add_row(MODE_INSERT, 32'h1234_5678, 16'h0005, 1, 1, STATUS_OK, 32'h0, 5'd3);
    add_row(MODE_REMOVE, 32'h0, 16'h0, 1, 1, STATUS_OK, 32'h0, 5'd2);
    add_row(MODE_REMOVE, 32'h0, 16'h0007, 1, 1, STATUS_NOT_FOUND, 32'h0, 5'd2);
    add_row(MODE_DEQUEUE, 32'h0, 16'h0, 1, 1, STATUS_OK, 32'hFFFF_FFFF, 5'd1);
    // duplicate tag: remove must take the older one
    add_row(MODE_INSERT, 32'hA5A5_A5A5, 16'h0005, 1, 0, '0, '0, '0);
    add_row(MODE_REMOVE, 32'h0, 16'h0005, 1, 0, '0, '0, '0);
    add_row(MODE_DEQUEUE, 32'h0, 16'h0, 1, 0, '0, '0, '0);
    // fill to the brim, then push past it
    add_row(MODE_INSERT, 32'h8000_0000, 16'h8000, QUEUE_DEPTH, 0, '0, '0, '0);
    add_row(MODE_INSERT, 32'h1, 16'h1, 1, 1, STATUS_FULL, 32'h0, 5'(QUEUE_DEPTH));
    add_row(MODE_UNUSED, 32'h0, 16'h0, 1, 1, STATUS_OK, 32'h0, 5'(QUEUE_DEPTH));
    // remove at the tail and at the head
    add_row(MODE_REMOVE, 32'h0, 16'h800F, 1, 0, '0, '0, '0);
    add_row(MODE_REMOVE, 32'h0, 16'h8000, 1, 0, '0, '0, '0);
    add_row(MODE_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 1, 0, '0, '0, '0);
    add_row(MODE_INSERT, 32'h5555_5555, 16'hAAAA, 1, 0, '0, '0, '0);
    add_row(MODE_INSERT, 32'h2, 16'h2, 1, 1, STATUS_FULL, 32'h0, 5'(QUEUE_DEPTH));
    // empty it completely
    add_row(MODE_DEQUEUE, 32'h0, 16'h0, QUEUE_DEPTH, 0, '0, '0, '0);
    add_row(MODE_DEQUEUE, 32'h0, 16'h0, 1, 1, STATUS_EMPTY, 32'h0, 5'd0);
    add_row(MODE_REMOVE, 32'h0, 16'h800F, 1, 1, STATUS_NOT_FOUND, 32'h0, 5'd0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[r]) begin
      row = stim_table[r];
      for (int k = 0; k < row.reps; k++) begin
        cmd = row.cmd;
        cmd.payload_in = row.cmd.payload_in + 32'(k);
        cmd.tag_in = row.cmd.tag_in + 16'(k);
        issue(cmd, row.typed, row.want);
      end
    end
    drain_pending();

    // Random traffic in phases that lean towards filling, draining, or neither
    counted = 0;
    mid_drained = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      quiet = (counted >= 300 && counted < 400);
      if (counted == 250 && !mid_drained) begin
        mid_drained = 1'b1;
        drain_pending();
      end
      case ((counted / 50) % 3)
        0:       begin ins_bound = 63; rem_bound = 83; end
        1:       begin ins_bound = 28; rem_bound = 58; end
        default: begin ins_bound = 43; rem_bound = 73; end
      endcase
      roll = $urandom_range(0, 99);
      cmd.payload_in = $urandom;
      cmd.tag_in = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      if (roll < 3) cmd.mode = MODE_UNUSED;
      else if (roll < ins_bound) cmd.mode = MODE_INSERT;
      else if (roll < rem_bound) cmd.mode = MODE_REMOVE;
      else cmd.mode = MODE_DEQUEUE;
      // mostly remove a tag that is actually held
      if (cmd.mode == MODE_REMOVE && held.size() != 0 && $urandom_range(0, 9) < 6) begin
        cmd.tag_in = held[$urandom_range(0, held.size() - 1)].tag;
      end
      issue(cmd, 1'b0, '0);
      if (cmd.mode != MODE_UNUSED) counted++;
    end
    quiet = 1'b0;
    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off once traffic is under way
  initial begin
    forever begin
      @(posedge clk);
      if (!held_off && accepted_reqs >= 150) begin
        held_off = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Check each response against the oldest expectation
  always @(posedge clk) begin
    fkr_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected response %0d: payload %h status %0d occupancy %0d",
                   rsp_count, rsp_data.payload_out, rsp_data.status, rsp_data.occupancy);
        end
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_data.payload_out !== want.payload_out || rsp_data.status !== want.status ||
            rsp_data.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Response %0d mismatch: expected payload %h status %0d occupancy %0d, %s",
                     rsp_count, want.payload_out, want.status, want.occupancy, "got");
            $display("  payload %h status %0d occupancy %0d",
                     rsp_data.payload_out, rsp_data.status, rsp_data.occupancy);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  initial begin
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) break;
    end
    $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule
